>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL of the bipartite CSR builder.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_NOW(name, cause, effect) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("assertion failed in bcsr");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(name, cause, effect) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed in bcsr");

`endif

>>> rtl/bcsr_pkg.sv
// ----------------------------------------------------------------------------
// bcsr_pkg
// Request codes, status codes, register indexes and field widths of the
// bipartite CSR builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcsr_pkg;

    localparam int REQ_W      = 2;
    localparam int NODE_ID_W  = 17;
    localparam int INDEX_W    = 13;
    localparam int STATUS_W   = 2;
    localparam int VALUE_W    = 17;
    localparam int DEGREE_W   = 13;
    localparam int ISO_W      = 11;
    localparam int TOTAL_W    = 14;
    localparam int COUNT_W    = 11;
    localparam int BASE_W     = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CAPACITY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_IN_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_IN_BASE = 2'd3;

endpackage

`default_nettype wire

>>> rtl/bipartite_csr_builder.sv
// ----------------------------------------------------------------------------
// bipartite_csr_builder
// Builds a symmetric bipartite CSR from a stream of element-to-node requests.
// ----------------------------------------------------------------------------
// Every request gets exactly one response. An edge or a read waits on the
// registered read of the vertex and edge memories, and an edge also on the
// read-modify-write of a node degree count. A build walks the tables, fills
// in the offsets of the elements never opened and scatters the edges of
// every element into the node lists.
// After reset, and on an open that follows a finished build, a clearing pass
// zeroes the node degree counts; no request is accepted meanwhile, while
// configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bipartite_csr_builder #(
    parameter int MAX_ELEMS = 1024,
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // node_id, read_index, zero pad
    input  wire logic [2:0]  s_tuser,   // req_type, read_array
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // read_value, max_degree, isolated_elems,
                                        // edge_total, zero pad
    output logic [1:0]       m_tuser,   // status
    input  wire logic        cfg_wen,
    input  wire logic [bcsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcsr_pkg::BASE_W-1:0]    cfg_wdata
);

    localparam int EW     = $clog2(MAX_ELEMS + 1);
    localparam int NW     = $clog2(MAX_NODES + 1);
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int VDEPTH = MAX_ELEMS + MAX_NODES + 1;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int EDEPTH = 2 * MAX_EDGES;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int VW     = (ECW + 1 > bcsr_pkg::VALUE_W) ? ECW + 1 : bcsr_pkg::VALUE_W;
    localparam int PMAX   = (VDEPTH > EDEPTH) ? VDEPTH : EDEPTH;
    localparam int PW     = $clog2(PMAX + 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_OPEN, ST_EDGE, ST_EDGE_WR, ST_READ, ST_READ_DATA,
        ST_BUILD, ST_CHK, ST_FILL, ST_PFX, ST_SC_E, ST_SC_T, ST_SC_K0, ST_SC_K1,
        ST_SC_K2, ST_FIN_V, ST_FIN_E, ST_DONE, ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [bcsr_pkg::COUNT_W-1:0] elem_count_reg, elem_count_next;
    logic [bcsr_pkg::COUNT_W-1:0] node_count_reg, node_count_next;
    logic [bcsr_pkg::BASE_W-1:0]  elem_base_reg, elem_base_next;
    logic [bcsr_pkg::BASE_W-1:0]  node_base_reg, node_base_next;

    logic [EW-1:0]  elem_cnt_reg, elem_cnt_next;
    logic [ECW-1:0] edge_cnt_reg, edge_cnt_next;
    logic           built_reg, built_next;
    logic [1:0]     err_reg, err_next;
    logic [ECW-1:0] dmax_reg, dmax_next;
    logic [EW-1:0]  iso_reg, iso_next;
    logic [EW-1:0]  built_elems_reg, built_elems_next;
    logic [NW-1:0]  built_nodes_reg, built_nodes_next;
    logic           open_pend_reg, open_pend_next;

    logic                           rd_arr_reg, rd_arr_next;
    logic [bcsr_pkg::NODE_ID_W-1:0] node_id_reg, node_id_next;
    logic [bcsr_pkg::INDEX_W-1:0]   rd_idx_reg, rd_idx_next;

    logic [PW-1:0]  ptr_reg, ptr_next;
    logic           pend_reg, pend_next;
    logic [EW-1:0]  e_reg, e_next;
    logic [ECW-1:0] s_reg, s_next;
    logic [ECW-1:0] t_reg, t_next;
    logic [VW-1:0]  run_reg, run_next;
    logic [VW-1:0]  prev_reg, prev_next;

    logic [bcsr_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [bcsr_pkg::VALUE_W-1:0]  res_value_reg, res_value_next;

    logic                          m_valid_reg, m_valid_next;
    logic [bcsr_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [bcsr_pkg::VALUE_W-1:0]  m_value_reg, m_value_next;
    logic [bcsr_pkg::DEGREE_W-1:0] m_dmax_reg, m_dmax_next;
    logic [bcsr_pkg::ISO_W-1:0]    m_iso_reg, m_iso_next;
    logic [bcsr_pkg::TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic [VW-1:0]  vt_mem [VDEPTH];
    logic           vt_we, vt_re;
    logic [VAW-1:0] vt_waddr, vt_raddr;
    logic [VW-1:0]  vt_wdata, vt_rdata_reg;

    logic [bcsr_pkg::VALUE_W-1:0] et_mem [EDEPTH];
    logic                         et_we, et_re;
    logic [EAW-1:0]               et_waddr, et_raddr;
    logic [bcsr_pkg::VALUE_W-1:0] et_wdata, et_rdata_reg;

    logic [EW-1:0]                  ne;
    logic [NW-1:0]                  nn;
    logic [bcsr_pkg::BASE_W-1:0]    base;
    logic [bcsr_pkg::NODE_ID_W-1:0] ln;
    logic [VAW-1:0]                 ln_addr;
    logic [PW-1:0]                  ptr_prev;
    logic [PW-1:0]                  last_v;
    logic [ECW-1:0]                 deg;
    logic [VW-1:0]                  fin_v;
    logic [VW:0]                    fin_sum;
    logic [18:0]                    fin_e_sum;

    assign ne = (32'(elem_count_reg) < MAX_ELEMS) ? EW'(elem_count_reg) : EW'(MAX_ELEMS);
    assign nn = (32'(node_count_reg) < MAX_NODES) ? NW'(node_count_reg) : NW'(MAX_NODES);
    assign base = (elem_base_reg < node_base_reg) ? elem_base_reg : node_base_reg;
    assign ln = node_id_reg - bcsr_pkg::NODE_ID_W'(node_base_reg);
    assign ln_addr = VAW'(MAX_ELEMS) + VAW'(ln);
    assign ptr_prev = ptr_reg - PW'(1);
    assign last_v = PW'(ne) + PW'(nn);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_total_reg, m_iso_reg, m_dmax_reg, m_value_reg};

    always_comb
    begin
        state_next       = state_reg;
        elem_count_next  = elem_count_reg;
        node_count_next  = node_count_reg;
        elem_base_next   = elem_base_reg;
        node_base_next   = node_base_reg;
        elem_cnt_next    = elem_cnt_reg;
        edge_cnt_next    = edge_cnt_reg;
        built_next       = built_reg;
        err_next         = err_reg;
        dmax_next        = dmax_reg;
        iso_next         = iso_reg;
        built_elems_next = built_elems_reg;
        built_nodes_next = built_nodes_reg;
        open_pend_next   = open_pend_reg;
        rd_arr_next      = rd_arr_reg;
        node_id_next     = node_id_reg;
        rd_idx_next      = rd_idx_reg;
        ptr_next         = ptr_reg;
        pend_next        = pend_reg;
        e_next           = e_reg;
        s_next           = s_reg;
        t_next           = t_reg;
        run_next         = run_reg;
        prev_next        = prev_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_value_next     = m_value_reg;
        m_dmax_next      = m_dmax_reg;
        m_iso_next       = m_iso_reg;
        m_total_next     = m_total_reg;
        vt_we    = 1'b0;
        vt_re    = 1'b0;
        vt_waddr = '0;
        vt_raddr = '0;
        vt_wdata = '0;
        et_we    = 1'b0;
        et_re    = 1'b0;
        et_waddr = '0;
        et_raddr = '0;
        et_wdata = '0;
        deg       = '0;
        fin_v     = '0;
        fin_sum   = '0;
        fin_e_sum = '0;

        if (cfg_wen)
        begin
            case (cfg_index)
                bcsr_pkg::CFG_ELEM_COUNT:   elem_count_next = cfg_wdata[bcsr_pkg::COUNT_W-1:0];
                bcsr_pkg::CFG_NODE_COUNT:   node_count_next = cfg_wdata[bcsr_pkg::COUNT_W-1:0];
                bcsr_pkg::CFG_ELEM_IN_BASE: elem_base_next  = cfg_wdata;
                bcsr_pkg::CFG_NODE_IN_BASE: node_base_next  = cfg_wdata;
                default:                    elem_count_next = elem_count_reg;
            endcase
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                vt_we    = 1'b1;
                vt_waddr = VAW'(MAX_ELEMS) + VAW'(ptr_reg);
                vt_wdata = '0;
                if (ptr_reg == PW'(MAX_NODES - 1))
                begin
                    ptr_next       = '0;
                    open_pend_next = 1'b0;
                    state_next     = open_pend_reg ? ST_OPEN : ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    rd_arr_next  = s_tuser[2];
                    node_id_next = s_tdata[16:0];
                    rd_idx_next  = s_tdata[29:17];
                    case (s_tuser[1:0])
                        bcsr_pkg::REQ_OPEN:
                        begin
                            if (built_reg)
                            begin
                                elem_cnt_next    = '0;
                                edge_cnt_next    = '0;
                                built_next       = 1'b0;
                                err_next         = 2'd0;
                                dmax_next        = '0;
                                iso_next         = '0;
                                built_elems_next = '0;
                                built_nodes_next = '0;
                                ptr_next         = '0;
                                open_pend_next   = 1'b1;
                                state_next       = ST_CLEAR;
                            end
                            else
                            begin
                                state_next = ST_OPEN;
                            end
                        end
                        bcsr_pkg::REQ_EDGE:  state_next = ST_EDGE;
                        bcsr_pkg::REQ_BUILD: state_next = ST_BUILD;
                        bcsr_pkg::REQ_READ:  state_next = ST_READ;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OPEN:
            begin
                res_value_next = '0;
                if (elem_cnt_reg < ne)
                begin
                    vt_we           = 1'b1;
                    vt_waddr        = VAW'(elem_cnt_reg);
                    vt_wdata        = VW'(edge_cnt_reg);
                    elem_cnt_next   = elem_cnt_reg + EW'(1);
                    res_status_next = bcsr_pkg::STAT_OK;
                end
                else
                begin
                    res_status_next = bcsr_pkg::STAT_CAPACITY;
                    if (err_reg == 2'd0)
                    begin
                        err_next = bcsr_pkg::STAT_CAPACITY;
                    end
                end
                state_next = ST_RESP;
            end
            ST_EDGE:
            begin
                res_value_next = '0;
                state_next     = ST_RESP;
                if (built_reg || elem_cnt_reg == '0)
                begin
                    res_status_next = bcsr_pkg::STAT_INVALID;
                end
                else if (node_id_reg < bcsr_pkg::NODE_ID_W'(node_base_reg) || ln >= nn)
                begin
                    res_status_next = bcsr_pkg::STAT_BAD_NODE;
                    if (err_reg == 2'd0)
                    begin
                        err_next = bcsr_pkg::STAT_BAD_NODE;
                    end
                end
                else if (32'(edge_cnt_reg) >= MAX_EDGES)
                begin
                    res_status_next = bcsr_pkg::STAT_CAPACITY;
                    if (err_reg == 2'd0)
                    begin
                        err_next = bcsr_pkg::STAT_CAPACITY;
                    end
                end
                else
                begin
                    et_we      = 1'b1;
                    et_waddr   = EAW'(edge_cnt_reg);
                    et_wdata   = ln;
                    vt_re      = 1'b1;
                    vt_raddr   = ln_addr;
                    state_next = ST_EDGE_WR;
                end
            end
            ST_EDGE_WR:
            begin
                vt_we           = 1'b1;
                vt_waddr        = ln_addr;
                vt_wdata        = vt_rdata_reg + VW'(1);
                edge_cnt_next   = edge_cnt_reg + ECW'(1);
                res_status_next = bcsr_pkg::STAT_OK;
                state_next      = ST_RESP;
            end
            ST_READ:
            begin
                res_value_next  = '0;
                res_status_next = bcsr_pkg::STAT_INVALID;
                state_next      = ST_RESP;
                if (built_reg)
                begin
                    if (!rd_arr_reg)
                    begin
                        if (32'(rd_idx_reg) <= 32'(built_elems_reg) + 32'(built_nodes_reg)
                            && 32'(rd_idx_reg) < VDEPTH)
                        begin
                            vt_re      = 1'b1;
                            vt_raddr   = VAW'(rd_idx_reg);
                            state_next = ST_READ_DATA;
                        end
                    end
                    else if (32'(rd_idx_reg) < 2 * 32'(edge_cnt_reg)
                             && 32'(rd_idx_reg) < EDEPTH)
                    begin
                        et_re      = 1'b1;
                        et_raddr   = EAW'(rd_idx_reg);
                        state_next = ST_READ_DATA;
                    end
                end
            end
            ST_READ_DATA:
            begin
                res_status_next = bcsr_pkg::STAT_OK;
                res_value_next  = rd_arr_reg ? et_rdata_reg
                                             : vt_rdata_reg[bcsr_pkg::VALUE_W-1:0];
                state_next      = ST_RESP;
            end
            ST_BUILD:
            begin
                res_value_next = '0;
                if (built_reg)
                begin
                    res_status_next = err_reg;
                    state_next      = ST_RESP;
                end
                else if (elem_cnt_reg > ne)
                begin
                    res_status_next = bcsr_pkg::STAT_CAPACITY;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ptr_next   = PW'(nn);
                    pend_next  = 1'b0;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (pend_reg && vt_rdata_reg != '0)
                begin
                    res_status_next = bcsr_pkg::STAT_BAD_NODE;
                    state_next      = ST_RESP;
                end
                else if (ptr_reg < PW'(MAX_NODES))
                begin
                    vt_re     = 1'b1;
                    vt_raddr  = VAW'(MAX_ELEMS) + VAW'(ptr_reg);
                    ptr_next  = ptr_reg + PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    ptr_next   = PW'(elem_cnt_reg);
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (ptr_reg < PW'(ne))
                begin
                    vt_we    = 1'b1;
                    vt_waddr = VAW'(ptr_reg);
                    vt_wdata = VW'(edge_cnt_reg);
                    ptr_next = ptr_reg + PW'(1);
                end
                else
                begin
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    run_next   = VW'(edge_cnt_reg);
                    state_next = ST_PFX;
                end
            end
            ST_PFX:
            begin
                if (ptr_reg < PW'(nn))
                begin
                    vt_re     = 1'b1;
                    vt_raddr  = VAW'(MAX_ELEMS) + VAW'(ptr_reg);
                    ptr_next  = ptr_reg + PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    deg      = ECW'(vt_rdata_reg);
                    vt_we    = 1'b1;
                    vt_waddr = VAW'(ne) + VAW'(ptr_prev);
                    vt_wdata = run_reg;
                    run_next = run_reg + vt_rdata_reg;
                    if (deg > dmax_reg)
                    begin
                        dmax_next = deg;
                    end
                end
                else if (!(ptr_reg < PW'(nn)))
                begin
                    vt_we      = 1'b1;
                    vt_waddr   = VAW'(ne) + VAW'(nn);
                    vt_wdata   = run_reg;
                    e_next     = '0;
                    s_next     = '0;
                    state_next = ST_SC_E;
                end
            end
            ST_SC_E:
            begin
                if (e_reg == ne)
                begin
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_FIN_V;
                end
                else
                begin
                    if (32'(e_reg) + 1 < 32'(ne))
                    begin
                        vt_re    = 1'b1;
                        vt_raddr = VAW'(e_reg) + VAW'(1);
                    end
                    state_next = ST_SC_T;
                end
            end
            ST_SC_T:
            begin
                t_next = (32'(e_reg) + 1 < 32'(ne)) ? ECW'(vt_rdata_reg) : edge_cnt_reg;
                deg    = t_next - s_reg;
                if (deg > dmax_reg)
                begin
                    dmax_next = deg;
                end
                if (deg == '0)
                begin
                    iso_next = iso_reg + EW'(1);
                end
                ptr_next   = PW'(s_reg);
                state_next = ST_SC_K0;
            end
            ST_SC_K0:
            begin
                if (ptr_reg == PW'(t_reg))
                begin
                    s_next     = t_reg;
                    e_next     = e_reg + EW'(1);
                    state_next = ST_SC_E;
                end
                else
                begin
                    et_re      = 1'b1;
                    et_raddr   = EAW'(ptr_reg);
                    state_next = ST_SC_K1;
                end
            end
            ST_SC_K1:
            begin
                prev_next  = VW'(et_rdata_reg);
                vt_re      = 1'b1;
                vt_raddr   = VAW'(ne) + VAW'(et_rdata_reg);
                state_next = ST_SC_K2;
            end
            ST_SC_K2:
            begin
                et_we      = 1'b1;
                et_waddr   = EAW'(vt_rdata_reg);
                et_wdata   = bcsr_pkg::VALUE_W'(e_reg);
                vt_we      = 1'b1;
                vt_waddr   = VAW'(ne) + VAW'(prev_reg);
                vt_wdata   = vt_rdata_reg + VW'(1);
                ptr_next   = ptr_reg + PW'(1);
                state_next = ST_SC_K0;
            end
            ST_FIN_V:
            begin
                if (ptr_reg <= last_v)
                begin
                    vt_re     = 1'b1;
                    vt_raddr  = VAW'(ptr_reg);
                    ptr_next  = ptr_reg + PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (ptr_prev == last_v)
                    begin
                        fin_v = vt_rdata_reg;
                    end
                    else if (ptr_prev == PW'(ne))
                    begin
                        fin_v = VW'(edge_cnt_reg);
                    end
                    else if (ptr_prev > PW'(ne))
                    begin
                        fin_v = prev_reg;
                    end
                    else
                    begin
                        fin_v = vt_rdata_reg;
                    end
                    fin_sum   = {1'b0, fin_v} + (VW + 1)'(base);
                    vt_we     = 1'b1;
                    vt_waddr  = VAW'(ptr_prev);
                    vt_wdata  = VW'(fin_sum[bcsr_pkg::VALUE_W-1:0]);
                    prev_next = vt_rdata_reg;
                end
                else if (!(ptr_reg <= last_v))
                begin
                    ptr_next   = '0;
                    state_next = ST_FIN_E;
                end
            end
            ST_FIN_E:
            begin
                if (ptr_reg < PW'({edge_cnt_reg, 1'b0}))
                begin
                    et_re     = 1'b1;
                    et_raddr  = EAW'(ptr_reg);
                    ptr_next  = ptr_reg + PW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    fin_e_sum = 19'(et_rdata_reg) + 19'(base)
                              + ((ptr_prev < PW'(edge_cnt_reg)) ? 19'(ne) : 19'd0);
                    et_we     = 1'b1;
                    et_waddr  = EAW'(ptr_prev);
                    et_wdata  = fin_e_sum[bcsr_pkg::VALUE_W-1:0];
                end
                else if (!(ptr_reg < PW'({edge_cnt_reg, 1'b0})))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                built_next       = 1'b1;
                built_elems_next = ne;
                built_nodes_next = nn;
                res_status_next  = err_reg;
                state_next       = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_dmax_next   = bcsr_pkg::DEGREE_W'(dmax_reg);
                    m_iso_next    = bcsr_pkg::ISO_W'(iso_reg);
                    m_total_next  = built_reg ? bcsr_pkg::TOTAL_W'({edge_cnt_reg, 1'b0})
                                              : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            elem_count_reg  <= '0;
            node_count_reg  <= '0;
            elem_base_reg   <= '0;
            node_base_reg   <= '0;
            elem_cnt_reg    <= '0;
            edge_cnt_reg    <= '0;
            built_reg       <= 1'b0;
            err_reg         <= 2'd0;
            dmax_reg        <= '0;
            iso_reg         <= '0;
            built_elems_reg <= '0;
            built_nodes_reg <= '0;
            open_pend_reg   <= 1'b0;
            ptr_reg         <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            elem_count_reg  <= elem_count_next;
            node_count_reg  <= node_count_next;
            elem_base_reg   <= elem_base_next;
            node_base_reg   <= node_base_next;
            elem_cnt_reg    <= elem_cnt_next;
            edge_cnt_reg    <= edge_cnt_next;
            built_reg       <= built_next;
            err_reg         <= err_next;
            dmax_reg        <= dmax_next;
            iso_reg         <= iso_next;
            built_elems_reg <= built_elems_next;
            built_nodes_reg <= built_nodes_next;
            open_pend_reg   <= open_pend_next;
            ptr_reg         <= ptr_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_arr_reg     <= rd_arr_next;
        node_id_reg    <= node_id_next;
        rd_idx_reg     <= rd_idx_next;
        e_reg          <= e_next;
        s_reg          <= s_next;
        t_reg          <= t_next;
        run_reg        <= run_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_dmax_reg     <= m_dmax_next;
        m_iso_reg      <= m_iso_next;
        m_total_reg    <= m_total_next;
    end

    always_ff @(posedge clk)
    begin
        if (vt_we)
        begin
            vt_mem[vt_waddr] <= vt_wdata;
        end
        if (vt_re)
        begin
            vt_rdata_reg <= vt_mem[vt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (et_we)
        begin
            et_mem[et_waddr] <= et_wdata;
        end
        if (et_re)
        begin
            et_rdata_reg <= et_mem[et_raddr];
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_NOW(a_built_from_done, $rose(built_reg), $past(state_reg == ST_DONE))
    `ASSERT_NOW(a_vt_addr_range, vt_we || vt_re, 32'(vt_waddr) < VDEPTH && 32'(vt_raddr) < VDEPTH)
    `ASSERT_NOW(a_et_addr_range, et_we || et_re, 32'(et_waddr) < EDEPTH && 32'(et_raddr) < EDEPTH)

endmodule

`default_nettype wire
